### hw/rtl/hfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg
// Types, sizes and helpers for the hypercube flow step unit.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int MAX_LOCI   = 6;
  localparam int VALUE_BITS = 32;
  localparam int RATE_BITS  = 16;

  localparam int NVERT  = 1 << MAX_LOCI;
  localparam int VERT_W = MAX_LOCI;
  localparam int LOCI_W = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
  localparam int EFF_W  = $clog2(MAX_LOCI + 1);
  localparam int CFG_W  = 3;

  // product of a signed value and a zero-extended rate
  localparam int PROD_W = VALUE_BITS + RATE_BITS + 1;
  // room for 2*MAX_LOCI products plus the rounding constant
  localparam int ACC_W  = PROD_W + $clog2(2 * MAX_LOCI) + 1;
  localparam int SH_W   = ACC_W - RATE_BITS;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LOCI = 1'b0;

  localparam logic [CFG_W-1:0] LOCI_RESET = CFG_W'(MAX_LOCI);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (RATE_BITS - 1);

  typedef enum logic [1:0] {
    OP_WR_VALUE = 2'd0,
    OP_WR_RATE  = 2'd1,
    OP_FILL     = 2'd2,
    OP_STEP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [5:0]             vertex;
    logic [2:0]             dimension;
    logic signed [31:0]     pop_value;
    logic [15:0]            rate_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]             out_vertex;
    logic signed [31:0]     new_value;
    logic                   last;
  } out_item_t;

  typedef logic [MAX_LOCI-1:0][RATE_BITS-1:0] rate_row_t;

  // signed saturation of a wide value to VALUE_BITS
  function automatic logic signed [VALUE_BITS-1:0] sat_value(
    input logic signed [SH_W-1:0] x
  );
    logic [SH_W-VALUE_BITS:0] top;
    logic signed [VALUE_BITS-1:0] res;
    top = x[SH_W-1:VALUE_BITS-1];
    if (&top || ~|top) begin
      res = x[VALUE_BITS-1:0];
    end else if (x[SH_W-1]) begin
      res = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### hw/rtl/hypercube_flow_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercube_flow_step_unit
// Per-vertex values and per-vertex/dimension rates on a binary hypercube; a
// step computes every net flow with one shared multiplier, then updates values.
// ----------------------------------------------------------------------------
// Loads (value, rate, fill) are taken only in the idle state and emit nothing.
// A step with L dimensions and N = 2^L vertices runs a flow pass, visiting RD,
//   MULJ, MULI and ACC for each vertex and dimension on the shared multiplier
//   and FLOW for each vertex, then RD2 and OUT per emitted vertex; OUT waits on output stalls.
// Reset: control cleared, loci_in_use = 6, all rates read as zero via row
//   valid bits; value storage is undefined until written.
module hypercube_flow_step_unit
  import hfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_MULJ = 8'b0000_0100,
    S_MULI = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_FLOW = 8'b0010_0000,
    S_RD2  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [VERT_W-1:0] i_r, i_nxt;
  logic [LOCI_W-1:0] k_r, k_nxt;
  logic [CFG_W-1:0]  loci_r, loci_nxt;
  logic [RATE_BITS-1:0] fill_r, fill_nxt;
  logic [NVERT-1:0]  rvalid_r, rvalid_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // storage
  logic signed [VALUE_BITS-1:0] value_mem [NVERT];
  logic signed [VALUE_BITS-1:0] flow_mem  [NVERT];
  rate_row_t                    rate_mem  [NVERT];

  logic signed [VALUE_BITS-1:0] vj_r, vi_r, fi_r;
  rate_row_t                    rowj_r, rowi_r;
  logic                         rvj_r, rvi_r;

  logic                 in_acc;
  logic                 cfg_wr;
  logic [EFF_W-1:0]     eff;
  logic [VERT_W:0]      npow;
  logic [VERT_W-1:0]    vmask;
  logic [VERT_W-1:0]    j_addr;
  logic                 k_last;
  logic                 i_last;
  logic                 out_free;
  logic [RATE_BITS-1:0] rate_j, rate_i;
  logic signed [VALUE_BITS-1:0] mul_a;
  logic [RATE_BITS-1:0]         mul_b;
  logic signed [ACC_W-1:0]      rsum;
  logic signed [SH_W-1:0]       rshift;
  logic signed [VALUE_BITS-1:0] flow_val;
  logic signed [VALUE_BITS-1:0] new_val;
  logic [VERT_W-1:0]            wr_vert;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOCI);
  assign prdata = (paddr[2] == REG_LOCI) ? CFG_DATA_W'(loci_r) : '0;

  always_comb begin
    if (loci_r == '0) begin
      eff = EFF_W'(1);
    end else if (loci_r > CFG_W'(MAX_LOCI)) begin
      eff = EFF_W'(MAX_LOCI);
    end else begin
      eff = EFF_W'(loci_r);
    end
  end

  assign npow    = (VERT_W + 1)'(1) << eff;
  assign vmask   = VERT_W'(npow - (VERT_W + 1)'(1));
  assign j_addr  = i_r ^ (VERT_W'(1) << k_r);
  assign k_last  = (EFF_W'(k_r) == (eff - EFF_W'(1)));
  assign i_last  = (i_r == vmask);
  assign wr_vert = in_data.vertex[VERT_W-1:0];

  assign rate_j = rvj_r ? rowj_r[k_r] : fill_r;
  assign rate_i = rvi_r ? rowi_r[k_r] : fill_r;
  assign mul_a  = (state_r == S_MULJ) ? vj_r : vi_r;
  assign mul_b  = (state_r == S_MULJ) ? rate_j : rate_i;

  assign rsum     = acc_r + ROUND_HALF;
  assign rshift   = SH_W'(rsum >>> RATE_BITS);
  assign flow_val = sat_value(rshift);
  assign new_val  = sat_value(SH_W'(vi_r) + SH_W'(fi_r));

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    loci_nxt      = loci_r;
    fill_nxt      = fill_r;
    rvalid_nxt    = rvalid_r;
    acc_nxt       = acc_r;
    prod_nxt      = PROD_W'($signed(mul_a) * $signed({1'b0, mul_b}));
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_wr) begin
      loci_nxt = pwdata[CFG_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.op)
            OP_WR_VALUE: ;
            OP_WR_RATE: begin
              if (in_data.dimension < 3'(MAX_LOCI)) begin
                rvalid_nxt[wr_vert] = 1'b1;
              end
            end
            OP_FILL: begin
              fill_nxt   = in_data.rate_value[RATE_BITS-1:0];
              rvalid_nxt = '0;
            end
            OP_STEP: begin
              i_nxt     = '0;
              k_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_MULJ;
      S_MULJ: state_nxt = S_MULI;
      S_MULI: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r - ACC_W'(prod_r);
        if (k_last) begin
          state_nxt = S_FLOW;
        end else begin
          k_nxt     = k_r + LOCI_W'(1);
          state_nxt = S_RD;
        end
      end
      S_FLOW: begin
        acc_nxt = '0;
        k_nxt   = '0;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_RD2;
        end else begin
          i_nxt     = i_r + VERT_W'(1);
          state_nxt = S_RD;
        end
      end
      S_RD2: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_vertex = 6'(i_r);
          out_data_nxt.new_value  = new_val;
          out_data_nxt.last       = i_last;
          if (i_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + VERT_W'(1);
            state_nxt = S_RD2;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      k_r         <= '0;
      loci_r      <= LOCI_RESET;
      fill_r      <= '0;
      rvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      loci_r      <= loci_nxt;
      fill_r      <= fill_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // value store: load port, update port, two read ports
  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == OP_WR_VALUE) begin
      value_mem[wr_vert] <= in_data.pop_value;
    end else if (state_r == S_OUT && out_free) begin
      value_mem[i_r] <= new_val;
    end
    if (state_r == S_RD || state_r == S_RD2) begin
      vi_r <= value_mem[i_r];
      vj_r <= value_mem[j_addr];
    end
  end

  // rate store: lane write; a row not yet valid takes the fill rate elsewhere
  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == OP_WR_RATE && in_data.dimension < 3'(MAX_LOCI)) begin
      for (int ln = 0; ln < MAX_LOCI; ln++) begin
        if (in_data.dimension[LOCI_W-1:0] == LOCI_W'(ln)) begin
          rate_mem[wr_vert][ln] <= in_data.rate_value[RATE_BITS-1:0];
        end else if (!rvalid_r[wr_vert]) begin
          rate_mem[wr_vert][ln] <= fill_r;
        end
      end
    end
    if (state_r == S_RD) begin
      rowi_r <= rate_mem[i_r];
      rowj_r <= rate_mem[j_addr];
      rvi_r  <= rvalid_r[i_r];
      rvj_r  <= rvalid_r[j_addr];
    end
  end

  // flow store
  always_ff @(posedge clk) begin
    if (state_r == S_FLOW) begin
      flow_mem[i_r] <= flow_val;
    end
    if (state_r == S_RD2) begin
      fi_r <= flow_mem[i_r];
    end
  end

endmodule

### tb/hypercube_flow_step_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercube_flow_step_unit_checker
// Watches the item, result and register ports of the flow step unit. It
// keeps its own copy of vertex values, rates and the loci setting, and works
// out every new vertex value of a step from the accepted items. It then
// compares each result transaction, field by field, with the oldest
// outstanding value.
// ----------------------------------------------------------------------------
module hypercube_flow_step_unit_checker
  import hfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    error_count,
  output int                    pending,
  output int                    result_count
);

  localparam logic [CFG_ADDR_W-1:0] LOCI_ADDR = CFG_ADDR_W'(4 * REG_LOCI);
  localparam int    REPORT_MAX = 10;
  localparam longint HALF_LSB  = longint'(1) << (RATE_BITS - 1);

  logic signed [VALUE_BITS-1:0] level_mem [NVERT];
  logic [RATE_BITS-1:0]         rate_mem  [NVERT][MAX_LOCI];
  logic [CFG_W-1:0]             loci_reg;
  out_item_t                    pending_levels [$];
  out_item_t                    want;
  int                           errors  = 0;
  int                           results = 0;

  function automatic logic signed [VALUE_BITS-1:0] clamp_value(input longint x);
    longint hi, lo;
    hi = (longint'(1) << (VALUE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      x = hi;
    end else if (x < lo) begin
      x = lo;
    end
    return VALUE_BITS'(x);
  endfunction

  // Net flows use the old values of every vertex; updates are applied together.
  function automatic void predict_flow_step();
    int dims, n, i, j, k;
    longint net, own_level, nbr_level, own_rate, nbr_rate;
    logic signed [VALUE_BITS-1:0] flow;
    logic signed [VALUE_BITS-1:0] next_level [NVERT];
    out_item_t res;
    dims = (loci_reg == 0) ? 1 : ((loci_reg > MAX_LOCI) ? MAX_LOCI : int'(loci_reg));
    n = 1 << dims;
    for (i = 0; i < n; i++) begin
      net = 0;
      for (k = 0; k < dims; k++) begin
        j = i ^ (1 << k);
        own_level = level_mem[i];
        nbr_level = level_mem[j];
        own_rate  = rate_mem[i][k];
        nbr_rate  = rate_mem[j][k];
        net += nbr_level * nbr_rate - own_level * own_rate;
      end
      flow = clamp_value((net + HALF_LSB) >>> RATE_BITS);
      own_level = level_mem[i];
      next_level[i] = clamp_value(own_level + longint'(flow));
    end
    for (i = 0; i < n; i++) begin
      level_mem[i]   = next_level[i];
      res.out_vertex = VERT_W'(i);
      res.new_value  = next_level[i];
      res.last       = (i == n - 1);
      pending_levels.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (rate_mem[v, d]) rate_mem[v][d] = '0;
      foreach (level_mem[v]) level_mem[v] = '0;
      loci_reg = LOCI_RESET;
      pending_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LOCI_ADDR) begin
        loci_reg = pwdata[CFG_W-1:0];
      end

      if (out_valid && !out_stall) begin
        results++;
        if (pending_levels.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("unexpected result transaction: vertex %0d value %h last %b",
                     out_data.out_vertex, out_data.new_value, out_data.last);
          end
        end else begin
          want = pending_levels.pop_front();
          if (out_data.out_vertex !== want.out_vertex ||
              out_data.new_value  !== want.new_value  ||
              out_data.last       !== want.last) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display({"result %0d mismatch: expected vertex %0d value %h last %b,",
                        " got vertex %0d value %h last %b"},
                       results, want.out_vertex, want.new_value, want.last,
                       out_data.out_vertex, out_data.new_value, out_data.last);
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_data.op)
          OP_WR_VALUE: begin
            level_mem[in_data.vertex] = in_data.pop_value;
          end
          OP_WR_RATE: begin
            if (in_data.dimension < MAX_LOCI) begin
              rate_mem[in_data.vertex][in_data.dimension] = in_data.rate_value;
            end
          end
          OP_FILL: begin
            foreach (rate_mem[v, d]) rate_mem[v][d] = in_data.rate_value;
          end
          OP_STEP: begin
            predict_flow_step();
          end
        endcase
      end
    end
    pending      <= pending_levels.size();
    error_count  <= errors;
    result_count <= results;
  end

endmodule

### tb/hypercube_flow_step_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercube_flow_step_unit_test
// Stimulus and verdict for the hypercube flow step unit. A directed opening
// covers value and rate extremes, ignored dimensions, out-of-cube vertices,
// fills, rounding ties and out-of-range loci settings. Random phases follow
// at several loci settings with sender gaps, output stalls, one long output
// hold and one full drain. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module hypercube_flow_step_unit_test;
  import hfs_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 2000;
  localparam int PHASE_ITEMS   = 13;
  localparam int NUM_PHASES    = 5;
  localparam int HOLD_PHASE    = 2;
  localparam int DRAIN_PHASE   = 4;
  localparam logic [CFG_ADDR_W-1:0] LOCI_ADDR = CFG_ADDR_W'(4 * REG_LOCI);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int error_count, pending, result_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_order    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int item_count    = 0;
  int step_count    = 0;
  logic [CFG_W-1:0] loci_now;
  logic [NVERT-1:0] loaded;

  int phase_loci  [NUM_PHASES] = '{6, 3, 4, 2, 5};
  int phase_idle  [NUM_PHASES] = '{0, 75, 0, 14, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 75, 14, 0};

  hypercube_flow_step_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hypercube_flow_step_unit_checker flow_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .error_count (error_count),
    .pending     (pending),
    .result_count(result_count)
  );

  always #1 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, or a long hold when one is ordered
  always @(negedge clk) begin
    if (hold_order != hold_served) begin
      hold_served = hold_order;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] random_level();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(3))
      0: return raw;
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $signed(raw) >>> $urandom_range(12, 2);
    endcase
  endfunction

  function automatic logic [15:0] random_rate();
    logic [15:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(3))
      0: return raw;
      1: return 16'hFFFF;
      2: return 16'h0000;
      default: return raw >> $urandom_range(8, 1);
    endcase
  endfunction

  function automatic in_item_t form_item(input op_t op, input logic [5:0] vtx,
                                         input logic [2:0] dim, input logic [31:0] level,
                                         input logic [15:0] rate);
    in_item_t it;
    it.op         = op;
    it.vertex     = vtx;
    it.dimension  = dim;
    it.pop_value  = level;
    it.rate_value = rate;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 35) begin
      op = OP_WR_VALUE;
    end else if (pick < 68) begin
      op = OP_WR_RATE;
    end else if (pick < 73) begin
      op = OP_FILL;
    end else begin
      op = OP_STEP;
    end
    return form_item(op, 6'($urandom), 3'($urandom), random_level(), random_rate());
  endfunction

  function automatic int active_vertices();
    int dims;
    dims = (loci_now == 0) ? 1 : ((loci_now > MAX_LOCI) ? MAX_LOCI : int'(loci_now));
    return 1 << dims;
  endfunction

  // Starts and ends at a falling edge; valid stays up for a back-to-back item.
  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    item_count++;
    if (it.op == OP_STEP) step_count++;
    if (it.op == OP_WR_VALUE) loaded[it.vertex] = 1'b1;
    @(negedge clk);
  endtask

  // A step only after every vertex in the active cube holds a value.
  task automatic issue(input in_item_t it);
    int n, v;
    if (it.op == OP_STEP) begin
      n = active_vertices();
      for (v = 0; v < n; v++) begin
        if (!loaded[v]) begin
          push_item(form_item(OP_WR_VALUE, 6'(v), 3'($urandom), random_level(),
                              16'($urandom)));
        end
      end
    end
    push_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_loci(input logic [CFG_W-1:0] setting);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[CFG_W-1:0] = setting;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LOCI_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    loci_now = setting;
  endtask

  initial begin
    int phase, n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    loci_now = LOCI_RESET;
    loaded   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // loci 0 behaves as a single dimension
    write_loci(3'd0);
    issue(form_item(OP_WR_VALUE, 6'd0, 3'd0, 32'h7FFF_FFFF, 16'h0000));
    issue(form_item(OP_WR_VALUE, 6'd1, 3'd0, 32'h8000_0000, 16'h0000));
    issue(form_item(OP_WR_RATE, 6'd0, 3'd0, 32'h0, 16'hFFFF));
    issue(form_item(OP_WR_RATE, 6'd1, 3'd0, 32'h0, 16'hFFFF));
    issue(form_item(OP_WR_RATE, 6'd1, 3'd7, 32'h0, 16'hAAAA));
    issue(form_item(OP_WR_RATE, 6'd0, 3'd6, 32'h0, 16'h1234));
    issue(form_item(OP_WR_RATE, 6'd0, 3'd3, 32'h0, 16'h5555));
    issue(form_item(OP_WR_VALUE, 6'd63, 3'd0, 32'h1234_5678, 16'h0000));
    issue(form_item(OP_STEP, 6'd63, 3'd7, 32'hFFFF_FFFF, 16'hFFFF));
    issue(form_item(OP_FILL, 6'd0, 3'd0, 32'h0, 16'h0000));
    issue(form_item(OP_STEP, 6'd0, 3'd0, 32'h0, 16'h0000));
    // rate one half: rounding tie on a one-LSB transfer
    issue(form_item(OP_FILL, 6'd0, 3'd0, 32'h0, 16'h8000));
    issue(form_item(OP_WR_VALUE, 6'd0, 3'd0, 32'h0000_0001, 16'h0000));
    issue(form_item(OP_WR_VALUE, 6'd1, 3'd0, 32'h0000_0000, 16'h0000));
    issue(form_item(OP_STEP, 6'd0, 3'd0, 32'h0, 16'h0000));
    issue(form_item(OP_WR_VALUE, 6'd0, 3'd0, 32'h4000_0000, 16'h0000));
    issue(form_item(OP_WR_VALUE, 6'd1, 3'd0, 32'hC000_0000, 16'h0000));
    issue(form_item(OP_STEP, 6'd0, 3'd0, 32'h0, 16'h0000));
    wait_idle();
    write_loci(3'd1);
    issue(form_item(OP_STEP, 6'd0, 3'd0, 32'h0, 16'h0000));
    // loci 7 behaves as the full cube
    wait_idle();
    write_loci(3'd7);
    issue(form_item(OP_FILL, 6'd0, 3'd0, 32'h0, 16'hFFFF));
    issue(form_item(OP_STEP, 6'd0, 3'd0, 32'h0, 16'h0000));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      write_loci(3'(phase_loci[phase]));
      send_idle_pct = phase_idle[phase];
      stall_pct     = phase_stall[phase];
      if (phase == HOLD_PHASE) begin
        // results back up behind the hold while the following items wait on the input stall
        hold_order++;
        issue(form_item(OP_STEP, 6'($urandom), 3'($urandom), random_level(), random_rate()));
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == DRAIN_PHASE && n == PHASE_ITEMS / 2) wait_idle();
        issue(random_item());
      end
    end

    stall_pct = 0;
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display({"Covered %0d input transactions (%0d steps) and %0d result",
              " transactions in %0d cycles,"},
             item_count, step_count, result_count, cycle_count);
    $display("loci settings 0 to 7, sender gaps, output stalls and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (error_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
